FILE: hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: hdl/bsra_pkg.sv
package bsra_pkg;

  localparam int SUM_W     = 32;
  localparam int CNT_W     = 8;
  localparam int GAIN_W    = 2;
  localparam int CFG_IDX_W = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP   = 2'd3;

  // gain codes at or above this one send three extra pulses
  localparam logic [GAIN_W-1:0] GAIN_TRIPLE = 2'd2;

  typedef struct packed {
    logic clear_run;
    logic clear_word;
    logic shift_en;
    logic finish;
    logic div_load;
    logic div_step;
    logic avg_store;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_stat_t;

endpackage

FILE: hdl/bsra_cfg.sv
module bsra_cfg
  import bsra_pkg::*;
#(
  parameter int TICK_WIDTH = 16,
  parameter int CFG_W = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output logic [GAIN_W-1:0]     gain_mode,
  output logic [CNT_W-1:0]      sample_count,
  output logic [TICK_WIDTH-1:0] half_period_ticks,
  output logic [TICK_WIDTH-1:0] gap_ticks
);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_mode         <= '0;
      sample_count      <= CNT_W'(1);
      half_period_ticks <= TICK_WIDTH'(1);
      gap_ticks         <= '0;
    end else if (wr_en) begin
      unique case (cfg_index)
        REG_GAIN:  gain_mode         <= cfg_data[GAIN_W-1:0];
        REG_COUNT: sample_count      <= cfg_data[CNT_W-1:0];
        REG_HALF:  half_period_ticks <= cfg_data[TICK_WIDTH-1:0];
        REG_GAP:   gap_ticks         <= cfg_data[TICK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/bsra_dp.sv
module bsra_dp
  import bsra_pkg::*;
#(
  parameter int DATA_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 dout_level,
  input  logic [CNT_W-1:0]     count,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic [DATA_BITS-1:0] average,
  output logic [DATA_BITS-1:0] last_sample
);

  localparam int DC_W = $clog2(SUM_W);

  logic [DATA_BITS-1:0] shift_word;
  logic [SUM_W-1:0]     sum_acc;
  logic [SUM_W-1:0]     ext;

  logic [SUM_W-1:0]     div_q;
  logic [CNT_W-1:0]     div_rem;
  logic [CNT_W-1:0]     div_den;
  logic                 div_neg;
  logic [DC_W-1:0]      div_cnt;
  logic [CNT_W:0]       rem_sh;
  logic                 rem_ge;
  logic [SUM_W-1:0]     q_signed;

  assign ext      = SUM_W'($signed(shift_word));
  assign rem_sh   = {div_rem, div_q[SUM_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, div_den};
  assign q_signed = div_neg ? (~div_q + 1'b1) : div_q;

  assign stat.div_last = (div_cnt == DC_W'(SUM_W - 1));

  // serial word, running sum and reported values
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_word  <= '0;
      sum_acc     <= '0;
      last_sample <= '0;
      average     <= '0;
    end else begin
      if (cmd.clear_word) begin
        shift_word <= '0;
      end else if (cmd.shift_en) begin
        shift_word <= {shift_word[DATA_BITS-2:0], dout_level};
      end
      if (cmd.clear_run) begin
        sum_acc <= '0;
      end else if (cmd.finish) begin
        sum_acc <= sum_acc + ext;
      end
      if (cmd.finish) begin
        last_sample <= shift_word;
      end
      if (cmd.avg_store) begin
        average <= q_signed[DATA_BITS-1:0];
      end
    end
  end

  // restoring divider on the magnitude, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_load) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_neg <= sum_acc[SUM_W-1];
      div_q   <= sum_acc[SUM_W-1] ? (~sum_acc + 1'b1) : sum_acc;
      div_rem <= '0;
      div_den <= count;
    end else if (cmd.div_step) begin
      div_rem <= rem_ge ? CNT_W'(rem_sh - {1'b0, div_den}) : rem_sh[CNT_W-1:0];
      div_q   <= {div_q[SUM_W-2:0], rem_ge};
    end
  end

endmodule

FILE: hdl/bsra_ctrl.sv
module bsra_ctrl
  import bsra_pkg::*;
#(
  parameter int DATA_BITS = 24,
  parameter int TICK_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  start_req,
  output logic                  busy,
  input  logic [GAIN_W-1:0]     gain_mode,
  input  logic [CNT_W-1:0]      sample_count,
  input  logic [TICK_WIDTH-1:0] half_period_ticks,
  input  logic [TICK_WIDTH-1:0] gap_ticks,
  output dp_cmd_t               cmd,
  input  dp_stat_t              stat,
  output logic                  result_valid,
  output logic                  sck_level,
  output logic                  busy_res,
  output logic                  done_res
);

  localparam int BI_W = $clog2(DATA_BITS + 4);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HIGH = 3'd1;
  localparam logic [2:0] PH_LOW  = 3'd2;
  localparam logic [2:0] PH_GAP  = 3'd3;

  localparam logic [1:0] CTL_RUN   = 2'd0;
  localparam logic [1:0] CTL_LOAD  = 2'd1;
  localparam logic [1:0] CTL_DIV   = 2'd2;
  localparam logic [1:0] CTL_STORE = 2'd3;

  logic [1:0]            ctl, ctl_next;
  logic [2:0]            phase, phase_next;
  logic [TICK_WIDTH-1:0] tick_count, tick_count_next;
  logic [BI_W-1:0]       bit_index, bit_index_next;
  logic [CNT_W-1:0]      samples_done, samples_done_next;

  logic                  accept;
  logic                  final_tick;
  logic [TICK_WIDTH-1:0] half_len;
  logic [TICK_WIDTH:0]   tick_inc;
  logic                  half_end;
  logic                  gap_end;
  logic [GAIN_W-1:0]     extra;
  logic [BI_W-1:0]       pulse_total;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      samples_inc;
  logic                  clear_run, clear_word, shift_en, finish;

  assign busy        = (ctl != CTL_RUN);
  assign accept      = start && !busy;
  assign half_len    = (half_period_ticks == '0) ? TICK_WIDTH'(1) : half_period_ticks;
  assign tick_inc    = {1'b0, tick_count} + 1'b1;
  assign half_end    = tick_inc >= {1'b0, half_len};
  assign gap_end     = tick_inc >= {1'b0, gap_ticks};
  assign extra       = (gain_mode >= GAIN_TRIPLE) ? 2'd3 : (gain_mode + 2'd1);
  assign pulse_total = BI_W'(DATA_BITS) + BI_W'(extra);
  assign count       = (sample_count == '0) ? CNT_W'(1) : sample_count;
  assign samples_inc = samples_done + 1'b1;

  // one tick of the readout sequence
  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    bit_index_next    = bit_index;
    samples_done_next = samples_done;
    clear_run         = 1'b0;
    clear_word        = 1'b0;
    shift_en          = 1'b0;
    finish            = 1'b0;
    final_tick        = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (start_req) begin
          clear_run         = 1'b1;
          clear_word        = 1'b1;
          samples_done_next = '0;
          phase_next        = PH_HIGH;
          tick_count_next   = '0;
          bit_index_next    = '0;
        end
      end
      PH_HIGH: begin
        if (half_end) begin
          shift_en        = (bit_index < BI_W'(DATA_BITS));
          bit_index_next  = bit_index + 1'b1;
          phase_next      = PH_LOW;
          tick_count_next = '0;
        end else begin
          tick_count_next = tick_inc[TICK_WIDTH-1:0];
        end
      end
      PH_LOW: begin
        if (half_end) begin
          tick_count_next = '0;
          if (bit_index < pulse_total) begin
            phase_next = PH_HIGH;
          end else begin
            finish            = 1'b1;
            samples_done_next = samples_inc;
            if (samples_inc >= count) begin
              final_tick = 1'b1;
              phase_next = PH_IDLE;
            end else if (gap_ticks == '0) begin
              clear_word     = 1'b1;
              bit_index_next = '0;
              phase_next     = PH_HIGH;
            end else begin
              phase_next = PH_GAP;
            end
          end
        end else begin
          tick_count_next = tick_inc[TICK_WIDTH-1:0];
        end
      end
      PH_GAP: begin
        if (gap_end) begin
          clear_word      = 1'b1;
          bit_index_next  = '0;
          tick_count_next = '0;
          phase_next      = PH_HIGH;
        end else begin
          tick_count_next = tick_inc[TICK_WIDTH-1:0];
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // division sequencing after the last reading
  always_comb begin
    ctl_next = ctl;
    unique case (ctl)
      CTL_RUN:   if (accept && final_tick) ctl_next = CTL_LOAD;
      CTL_LOAD:  ctl_next = CTL_DIV;
      CTL_DIV:   if (stat.div_last) ctl_next = CTL_STORE;
      CTL_STORE: ctl_next = CTL_RUN;
      default:   ctl_next = CTL_RUN;
    endcase
  end

  assign cmd.clear_run  = accept && clear_run;
  assign cmd.clear_word = accept && clear_word;
  assign cmd.shift_en   = accept && shift_en;
  assign cmd.finish     = accept && finish;
  assign cmd.div_load   = (ctl == CTL_LOAD);
  assign cmd.div_step   = (ctl == CTL_DIV);
  assign cmd.avg_store  = (ctl == CTL_STORE);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl          <= CTL_RUN;
      phase        <= PH_IDLE;
      tick_count   <= '0;
      bit_index    <= '0;
      samples_done <= '0;
      result_valid <= 1'b0;
      sck_level    <= 1'b0;
      busy_res     <= 1'b0;
      done_res     <= 1'b0;
    end else begin
      ctl          <= ctl_next;
      result_valid <= (accept && !final_tick) || (ctl == CTL_STORE);
      if (accept) begin
        phase        <= phase_next;
        tick_count   <= tick_count_next;
        bit_index    <= bit_index_next;
        samples_done <= samples_done_next;
        sck_level    <= (phase_next == PH_HIGH);
        busy_res     <= (phase_next != PH_IDLE);
        done_res     <= final_tick;
      end
    end
  end

endmodule

FILE: hdl/bridge_adc_serial_reader_averager.sv
// Readout of a two-wire 24-bit bridge converter with averaging.
// Each item is one timing tick: start_req and dout_level are offered with
// start, and the item is taken at a clock edge with start high and busy low.
// Every item gives one result: sck_level, busy_res, done_res, average and
// last_sample, shown for one cycle with result_valid high.
// An ordinary tick: the result appears the cycle after the item is taken, and
// busy stays low, so one tick per clock can be sustained.
// The tick that ends a run (last reading of sample_count): the block goes busy
// while a restoring divider forms the signed mean one quotient bit per cycle
// (a load, 32 steps, a store); the result is shown after the store.
// sck_level only changes when an item is taken, so the pin holds between ticks.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high and a write takes effect at once.
// Reset (rst, synchronous): the run state, sum, average and last sample clear,
// and the registers return to gain 0, one sample, half period 1, gap 0.
// The receiver cannot stall: each result is taken in the cycle it is shown.
`include "assert_macros.svh"

module bridge_adc_serial_reader_averager
  import bsra_pkg::*;
#(
  parameter int DATA_BITS = 24,
  parameter int TICK_WIDTH = 16,
  localparam int CFG_W = (TICK_WIDTH > CNT_W) ? TICK_WIDTH : CNT_W
) (
  input  logic                 clk,
  input  logic                 rst,
  // tick items
  input  logic                 start,
  output logic                 busy,
  input  logic                 start_req,
  input  logic                 dout_level,
  // results
  output logic                 result_valid,
  output logic                 sck_level,
  output logic                 busy_res,
  output logic                 done_res,
  output logic [DATA_BITS-1:0] average,
  output logic [DATA_BITS-1:0] last_sample,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [GAIN_W-1:0]     gain_mode;
  logic [CNT_W-1:0]      sample_count;
  logic [TICK_WIDTH-1:0] half_period_ticks;
  logic [TICK_WIDTH-1:0] gap_ticks;
  logic [CNT_W-1:0]      count;
  dp_cmd_t               cmd;
  dp_stat_t              stat;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // zero count behaves as one
  assign count = (sample_count == '0) ? CNT_W'(1) : sample_count;

  bsra_cfg #(
    .TICK_WIDTH(TICK_WIDTH),
    .CFG_W(CFG_W)
  ) u_cfg (
    .clk(clk),
    .rst(rst),
    .wr_en(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .gain_mode(gain_mode),
    .sample_count(sample_count),
    .half_period_ticks(half_period_ticks),
    .gap_ticks(gap_ticks)
  );

  // phase sequencer and division control
  bsra_ctrl #(
    .DATA_BITS(DATA_BITS),
    .TICK_WIDTH(TICK_WIDTH)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .start_req(start_req),
    .busy(busy),
    .gain_mode(gain_mode),
    .sample_count(sample_count),
    .half_period_ticks(half_period_ticks),
    .gap_ticks(gap_ticks),
    .cmd(cmd),
    .stat(stat),
    .result_valid(result_valid),
    .sck_level(sck_level),
    .busy_res(busy_res),
    .done_res(done_res)
  );

  // shift register, accumulator and divider
  bsra_dp #(
    .DATA_BITS(DATA_BITS)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .dout_level(dout_level),
    .count(count),
    .cmd(cmd),
    .stat(stat),
    .average(average),
    .last_sample(last_sample)
  );

  // a finished run never shows the clock high or the run still going
  `ASSERT_IMPLIES(a_done_idle, clk, rst, result_valid && done_res, !busy_res && !sck_level, "done result with run still active")

  // an ordinary result always belongs to the item taken just before
  `ASSERT_IMPLIES(a_tick_result, clk, rst, result_valid && !done_res, $past(start && !busy), "tick result without a taken item")

  // no result comes out while the divider runs
  `ASSERT_IMPLIES(a_no_result_busy, clk, rst, busy, !result_valid, "result shown while dividing")

  // the serial clock pin holds while the divider runs
  `ASSERT_NEXT(a_sck_hold, clk, rst, busy, $stable(sck_level), "serial clock moved while dividing")

endmodule

FILE: sim/tb_bridge_adc_serial_reader_averager.sv
module tb_bridge_adc_serial_reader_averager;
  import bsra_pkg::*;

  localparam int WORD_BITS   = 24;
  localparam int TICK_BITS   = 16;
  localparam int CFG_W       = (TICK_BITS > CNT_W) ? TICK_BITS : CNT_W;
  localparam int LIMIT_CYCLES = 2_000_000;
  // the tick that closes a run keeps the block busy while the divider works
  localparam int DIVIDE_CYCLES = 40;
  localparam int RANDOM_TICKS  = 300;

  // read sequencer phases as the block walks through one reading
  typedef enum logic [1:0] {RD_IDLE, RD_HIGH, RD_LOW, RD_GAP} read_phase_t;

  // what the converter pin presents for each reading
  typedef enum logic [1:0] {WORDS_MIXED, WORDS_MOST_NEG, WORDS_MOST_POS} word_pattern_t;

  typedef struct packed {
    logic                 sck;
    logic                 busy;
    logic                 done;
    logic [WORD_BITS-1:0] avg;
    logic [WORD_BITS-1:0] last;
  } tick_result_t;

  // tracks the readout state per tick and holds the results still owed
  class adc_avg_scoreboard;
    logic [GAIN_W-1:0]    gain;
    logic [CNT_W-1:0]     count_cfg;
    logic [TICK_BITS-1:0] half_cfg;
    logic [TICK_BITS-1:0] gap_cfg;

    read_phase_t          phase;
    int unsigned          bit_idx;
    int unsigned          tick_cnt;
    logic [WORD_BITS-1:0] shift_word;
    logic [SUM_W-1:0]     sum;
    logic [CNT_W-1:0]     samples_done;
    logic [WORD_BITS-1:0] avg_reg;
    logic [WORD_BITS-1:0] last_reg;
    int unsigned          reading_no;

    tick_result_t         expected_ticks[$];
    int                   errors;

    function new();
      gain = '0;
      count_cfg = 8'd1;
      half_cfg = 16'd1;
      gap_cfg = '0;
      phase = RD_IDLE;
      bit_idx = 0;
      tick_cnt = 0;
      shift_word = '0;
      sum = '0;
      samples_done = '0;
      avg_reg = '0;
      last_reg = '0;
      reading_no = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_GAIN:  gain = data[GAIN_W-1:0];
        REG_COUNT: count_cfg = data[CNT_W-1:0];
        REG_HALF:  half_cfg = data[TICK_BITS-1:0];
        REG_GAP:   gap_cfg = data[TICK_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned half_len();
      return (half_cfg == 0) ? 1 : half_cfg;
    endfunction

    function int unsigned gain_pulses();
      return (gain >= GAIN_TRIPLE) ? 3 : gain + 1;
    endfunction

    function void begin_reading();
      phase = RD_HIGH;
      tick_cnt = 0;
      bit_idx = 0;
      shift_word = '0;
      reading_no++;
    endfunction

    // signed mean, rounded toward zero
    function logic [WORD_BITS-1:0] signed_mean(logic [SUM_W-1:0] total, int unsigned n);
      logic [SUM_W-1:0] mag;
      logic [SUM_W-1:0] q;
      mag = total[SUM_W-1] ? -total : total;
      q = mag / n;
      if (total[SUM_W-1]) q = -q;
      return q[WORD_BITS-1:0];
    endfunction

    function void note_tick(logic start_bit, logic dout_bit);
      int unsigned  cnt;
      logic         done;
      tick_result_t r;
      done = 1'b0;
      cnt = (count_cfg == 0) ? 1 : count_cfg;
      case (phase)
        RD_IDLE: begin
          if (start_bit) begin
            sum = '0;
            samples_done = '0;
            begin_reading();
          end
        end
        RD_HIGH: begin
          if (tick_cnt + 1 >= half_len()) begin
            if (bit_idx < WORD_BITS) shift_word = {shift_word[WORD_BITS-2:0], dout_bit};
            bit_idx++;
            phase = RD_LOW;
            tick_cnt = 0;
          end else begin
            tick_cnt++;
          end
        end
        RD_LOW: begin
          if (tick_cnt + 1 >= half_len()) begin
            if (bit_idx < WORD_BITS + gain_pulses()) begin
              phase = RD_HIGH;
              tick_cnt = 0;
            end else begin
              last_reg = shift_word;
              sum = sum + {{(SUM_W-WORD_BITS){shift_word[WORD_BITS-1]}}, shift_word};
              samples_done = samples_done + 1'b1;
              if (samples_done >= cnt) begin
                avg_reg = signed_mean(sum, cnt);
                done = 1'b1;
                phase = RD_IDLE;
                tick_cnt = 0;
              end else if (gap_cfg == 0) begin
                begin_reading();
              end else begin
                phase = RD_GAP;
                tick_cnt = 0;
              end
            end
          end else begin
            tick_cnt++;
          end
        end
        default: begin
          if (tick_cnt + 1 >= gap_cfg) begin_reading();
          else tick_cnt++;
        end
      endcase
      r.sck = (phase == RD_HIGH);
      r.busy = (phase != RD_IDLE);
      r.done = done;
      r.avg = avg_reg;
      r.last = last_reg;
      expected_ticks.push_back(r);
    endfunction

    function void check_tick_result(tick_result_t got);
      tick_result_t want;
      if (expected_ticks.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result with no tick pending: sck=%0b busy=%0b done=%0b",
                   got.sck, got.busy, got.done);
        return;
      end
      want = expected_ticks.pop_front();
      if (got.sck !== want.sck || got.busy !== want.busy || got.done !== want.done ||
          got.avg !== want.avg || got.last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch: expected sck=%0b busy=%0b done=%0b avg=%h last=%h, ",
                    "got %0b %0b %0b %h %h"},
                   want.sck, want.busy, want.done, want.avg, want.last,
                   got.sck, got.busy, got.done, got.avg, got.last);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 start_req = 1'b0;
  logic                 dout_level = 1'b0;
  logic                 result_valid;
  logic                 sck_level;
  logic                 busy_res;
  logic                 done_res;
  logic [WORD_BITS-1:0] average;
  logic [WORD_BITS-1:0] last_sample;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  adc_avg_scoreboard    sb;
  int                   cycle_count = 0;
  int                   tick_total = 0;
  // word currently served by the modeled converter pin
  logic [WORD_BITS-1:0] cur_word = '0;
  int unsigned          word_reading = 0;
  word_pattern_t        pattern = WORDS_MIXED;

  always #6 clk = ~clk;

  bridge_adc_serial_reader_averager #(
    .DATA_BITS (WORD_BITS),
    .TICK_WIDTH(TICK_BITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .start_req   (start_req),
    .dout_level  (dout_level),
    .result_valid(result_valid),
    .sck_level   (sck_level),
    .busy_res    (busy_res),
    .done_res    (done_res),
    .average     (average),
    .last_sample (last_sample),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // results can't be held off, so every strobed cycle is checked at its closing edge
  always @(posedge clk) begin
    if (!rst && result_valid)
      sb.check_tick_result('{sck_level, busy_res, done_res, average, last_sample});
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_bridge_adc_serial_reader_averager: FAIL");
      $finish;
    end
  end

  // extremes show up often so sign extension and the averaging edges get hit
  function automatic logic [WORD_BITS-1:0] pick_word();
    case (pattern)
      WORDS_MOST_NEG: return {1'b1, {(WORD_BITS-1){1'b0}}};
      WORDS_MOST_POS: return {1'b0, {(WORD_BITS-1){1'b1}}};
      default: begin
        case ($urandom_range(7))
          0: return {1'b1, {(WORD_BITS-1){1'b0}}};
          1: return {1'b0, {(WORD_BITS-1){1'b1}}};
          2: return '0;
          3: return '1;
          default: return WORD_BITS'($urandom);
        endcase
      end
    endcase
  endfunction

  // one register write; valid stays up between back-to-back writes
  task automatic cfg_write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, data);
    @(negedge clk);
  endtask

  // one tick item; called at a falling edge, returns at a falling edge
  task automatic drive_tick();
    logic sr;
    logic dl;
    bit   steady;
    if (sb.reading_no != word_reading) begin
      word_reading = sb.reading_no;
      cur_word = pick_word();
    end
    // mostly start when idle, start requests during a run must be ignored
    sr = (sb.phase == RD_IDLE) ? ($urandom_range(99) < 70) : 1'($urandom_range(1));
    // serve the current word bit, with some pin noise in the mixed pattern
    if (sb.bit_idx < WORD_BITS && !(pattern == WORDS_MIXED && $urandom_range(99) < 8))
      dl = cur_word[WORD_BITS-1-sb.bit_idx];
    else
      dl = 1'($urandom_range(1));
    // a stretch in the middle of the run goes with no sender gaps at all
    steady = (tick_total >= 300 && tick_total < 900);
    while (!steady && $urandom_range(99) < 36) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    start_req <= sr;
    dout_level <= dl;
    do @(posedge clk); while (busy);
    sb.note_tick(sr, dl);
    tick_total++;
    @(negedge clk);
  endtask

  // settle, load all four registers, then run a batch of ticks
  task automatic run_phase(input logic [GAIN_W-1:0] g, input logic [CNT_W-1:0] c,
                           input logic [TICK_BITS-1:0] h, input logic [TICK_BITS-1:0] gp,
                           input int n, input word_pattern_t pat);
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    // extra settling; a run-ending tick shows its result only once the divider is done
    repeat (DIVIDE_CYCLES) @(negedge clk);
    cfg_write_reg(REG_GAIN, CFG_W'(g));
    cfg_write_reg(REG_COUNT, CFG_W'(c));
    cfg_write_reg(REG_HALF, CFG_W'(h));
    cfg_write_reg(REG_GAP, CFG_W'(gp));
    cfg_valid <= 1'b0;
    pattern = pat;
    repeat (n) drive_tick();
  endtask

  initial begin
    logic [GAIN_W-1:0]    g;
    logic [CNT_W-1:0]     c;
    logic [TICK_BITS-1:0] h;
    logic [TICK_BITS-1:0] gp;
    int                   est;
    int                   n;
    int                   random_ticks;
    int unsigned          ce;
    int unsigned          he;
    int unsigned          ex;

    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings, single reading
    run_phase(2'd0, 8'd1, 16'd1, 16'd0, 60, WORDS_MIXED);
    // zero half period taken as one, gain code three, most negative mean
    run_phase(2'd3, 8'd2, 16'd0, 16'd0, 115, WORDS_MOST_NEG);
    // two pulses, gap between readings, most positive mean
    run_phase(2'd1, 8'd3, 16'd1, 16'd2, 170, WORDS_MOST_POS);
    // zero sample count taken as one, three pulses, wider half period
    run_phase(2'd2, 8'd0, 16'd2, 16'd0, 120, WORDS_MIXED);
    // longest gap: first reading finishes and the run parks in the gap
    run_phase(2'd0, 8'd2, 16'd1, 16'hFFFF, 150, WORDS_MIXED);
    // live change: gap ends at once, then the longest half period
    run_phase(2'd2, 8'd255, 16'hFFFF, 16'd1, 40, WORDS_MIXED);
    // live change again: count drops and the run finishes with six readings
    run_phase(2'd0, 8'd6, 16'd1, 16'd0, 320, WORDS_MIXED);
    // average of four most negative words
    run_phase(2'd1, 8'd4, 16'd1, 16'd0, 220, WORDS_MOST_NEG);

    // random settings, mostly sized so runs complete, sometimes cut short
    random_ticks = 0;
    while (random_ticks < RANDOM_TICKS) begin
      g = GAIN_W'($urandom_range(0, 3));
      c = ($urandom_range(9) == 0) ? 8'd0 : CNT_W'($urandom_range(1, 3));
      case ($urandom_range(9))
        0: h = 16'd0;
        1, 2: h = 16'd2;
        3: h = 16'd3;
        default: h = 16'd1;
      endcase
      gp = ($urandom_range(7) == 0) ? 16'd30 : TICK_BITS'($urandom_range(0, 4));
      ex = (g >= GAIN_TRIPLE) ? 3 : g + 1;
      ce = (c == 0) ? 1 : c;
      he = (h == 0) ? 1 : h;
      est = ce * (WORD_BITS + ex) * 2 * he + (ce - 1) * gp + 2;
      n = ($urandom_range(5) == 0) ? est / 2 : est + $urandom_range(0, 30);
      run_phase(g, c, h, gp, n, WORDS_MIXED);
      random_ticks += n;
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DIVIDE_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_bridge_adc_serial_reader_averager: PASS");
    end else begin
      $display("tb_bridge_adc_serial_reader_averager: FAIL");
    end
    $finish;
  end

endmodule
